// ===== sv/sha1he_pkg.sv =====
// sha1 engine package: constants, round tables and shared widths
package sha1he_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned BLK_WORDS = 16;
    localparam int unsigned BLK_AW    = $clog2(BLK_WORDS);
    localparam int unsigned CHAIN_N   = 5;
    localparam int unsigned ROUNDS    = 80;
    localparam int unsigned RND_W     = 7;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // packed so that element 0 is H0
    localparam logic [CHAIN_N-1:0][WORD_W-1:0] H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [RND_W-1:0] RND_LAST = 7'(ROUNDS - 1);

    localparam logic [BLK_AW-1:0] IDX_LEN_HI = 4'd14;
    localparam logic [BLK_AW-1:0] IDX_LEN_LO = 4'd15;
    localparam logic [BLK_AW-1:0] IDX_LAST   = 4'd15;

    localparam logic [2:0] WORD_NUM_LAST = 3'd4;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                               input int unsigned n);
        rotl = (x << n) | (x >> (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] round_k(input logic [RND_W-1:0] t);
        case (t) inside
            [7'd0:7'd19]:  round_k = 32'h5A827999;
            [7'd20:7'd39]: round_k = 32'h6ED9EBA1;
            [7'd40:7'd59]: round_k = 32'h8F1BBCDC;
            default:       round_k = 32'hCA62C1D6;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] round_f(input logic [RND_W-1:0] t,
                                                  input logic [WORD_W-1:0] b,
                                                  input logic [WORD_W-1:0] c,
                                                  input logic [WORD_W-1:0] d);
        case (t) inside
            [7'd0:7'd19]:  round_f = (b & c) | (~b & d);
            [7'd40:7'd59]: round_f = (b & c) | (b & d) | (c & d);
            default:       round_f = b ^ c ^ d;
        endcase
    endfunction

endpackage

// ===== sv/sha1he_ram.sv =====
// generic single write port ram with one registered read port
module sha1he_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/sha1_hash_engine_core.sv =====
// sha1 engine: message bytes are taken while idle; a byte that fills the block starts a compression
// (one ram read lead-in, 80 rounds, one chain fold) during which o_stall holds the input
// an end beat writes the padding into the block ram (and a second block when it spills),
// compresses once (twice past 55 pending bytes) and streams five digest beats, one a cycle
// unless i_stall holds them; an end beat after a length overflow gives one error beat instead
// i_rst_n low at a clock edge restores the initial chain, clears counts and o_valid
module sha1_hash_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_number,
    output logic        o_ok,
    output logic        o_last_word
);
    import sha1he_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_CREAD = 6'b000100,
        S_ROUND = 6'b001000,
        S_FOLD  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state              r_state;
    logic [WORD_W-1:0]   r_acc;
    logic [5:0]          r_pos;
    logic [63:0]         r_bc;
    logic                r_ovf;
    logic [WORD_W-1:0]   r_h [CHAIN_N];
    logic [WORD_W-1:0]   r_a, r_b, r_c, r_d, r_e;
    logic [RND_W-1:0]    r_rnd;
    logic [WORD_W-1:0]   r_sched [BLK_WORDS];
    logic [BLK_AW-1:0]   r_widx;
    logic                r_first;
    logic                r_spill;
    logic                r_pad;
    logic                r_err;
    logic [2:0]          r_onum;
    logic                r_ovalid;
    logic [WORD_W-1:0]   r_odigest;
    logic [2:0]          r_onumber;
    logic                r_ook;
    logic                r_olast;

    logic                in_beat;
    logic                out_load;
    logic [7:0]          merge_byte;
    logic [WORD_W-1:0]   merged_word;
    logic [WORD_W-1:0]   pad_word;
    logic                ram_we;
    logic [BLK_AW-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [BLK_AW-1:0]   ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;
    logic [WORD_W-1:0]   round_w;
    logic [WORD_W-1:0]   round_tmp;
    logic [WORD_W-1:0]   sel_digest;
    logic [63:0]         n_bc;

    assign o_stall  = (r_state != S_IDLE);
    assign in_beat  = i_valid && (r_state == S_IDLE);
    assign out_load = (r_state == S_OUT) && (!r_ovalid || !i_stall);

    // keep the lanes above the current byte, place the byte, zero the rest
    assign merge_byte = i_kind ? PAD_BYTE : i_data_byte;
    always_comb begin
        case (r_pos[1:0])
            2'd0:    merged_word = {merge_byte, 24'h0};
            2'd1:    merged_word = {r_acc[31:24], merge_byte, 16'h0};
            2'd2:    merged_word = {r_acc[31:16], merge_byte, 8'h0};
            default: merged_word = {r_acc[31:8], merge_byte};
        endcase
    end

    always_comb begin
        if (r_first) begin
            pad_word = r_acc;
        end else if (!r_spill && r_widx == IDX_LEN_HI) begin
            pad_word = r_bc[63:32];
        end else if (!r_spill && r_widx == IDX_LEN_LO) begin
            pad_word = r_bc[31:0];
        end else begin
            pad_word = '0;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pos[5:2];
        ram_wdata = merged_word;
        if (r_state == S_PAD) begin
            ram_we    = 1'b1;
            ram_waddr = r_widx;
            ram_wdata = pad_word;
        end else if (in_beat && !i_kind && !r_ovf && r_pos[1:0] == 2'd3) begin
            ram_we = 1'b1;
        end
    end

    // the registered read is addressed in the cycle before the round that uses it
    always_comb begin
        if (r_state == S_ROUND) begin
            ram_raddr = r_rnd[BLK_AW-1:0] + 1'b1;
        end else begin
            ram_raddr = '0;
        end
    end

    sha1he_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BLK_WORDS)
    ) u_blk_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (r_rnd < RND_W'(BLK_WORDS)) begin
            round_w = ram_rdata;
        end else begin
            round_w = rotl(r_sched[13] ^ r_sched[8] ^ r_sched[2] ^ r_sched[0], 1);
        end
        round_tmp = rotl(r_a, 5) + round_f(r_rnd, r_b, r_c, r_d) + r_e + round_w
                  + round_k(r_rnd);
    end

    always_comb begin
        case (r_onum)
            3'd0:    sel_digest = r_h[0];
            3'd1:    sel_digest = r_h[1];
            3'd2:    sel_digest = r_h[2];
            3'd3:    sel_digest = r_h[3];
            default: sel_digest = r_h[4];
        endcase
    end

    assign n_bc = r_bc + 64'd8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pos    <= '0;
            r_bc     <= '0;
            r_ovf    <= 1'b0;
            r_rnd    <= '0;
            r_widx   <= '0;
            r_first  <= 1'b0;
            r_spill  <= 1'b0;
            r_pad    <= 1'b0;
            r_err    <= 1'b0;
            r_onum   <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < CHAIN_N; i++) begin
                r_h[i] <= H_INIT[i];
            end
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        if (!i_kind) begin
                            if (!r_ovf) begin
                                r_acc <= merged_word;
                                r_bc  <= n_bc;
                                if (n_bc == '0) begin
                                    r_ovf <= 1'b1;
                                end
                                r_pos <= r_pos + 1'b1;
                                if (r_pos == 6'd63) begin
                                    r_pad   <= 1'b0;
                                    r_state <= S_CREAD;
                                end
                            end
                        end else if (r_ovf) begin
                            r_err   <= 1'b1;
                            r_onum  <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_acc   <= merged_word;
                            r_widx  <= r_pos[5:2];
                            r_first <= 1'b1;
                            r_spill <= (r_pos[5:3] == 3'd7);
                            r_pad   <= 1'b1;
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_first <= 1'b0;
                    r_widx  <= r_widx + 1'b1;
                    if (r_widx == IDX_LAST) begin
                        r_state <= S_CREAD;
                    end
                end
                S_CREAD: begin
                    r_a     <= r_h[0];
                    r_b     <= r_h[1];
                    r_c     <= r_h[2];
                    r_d     <= r_h[3];
                    r_e     <= r_h[4];
                    r_rnd   <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    for (int i = 0; i < BLK_WORDS - 1; i++) begin
                        r_sched[i] <= r_sched[i+1];
                    end
                    r_sched[BLK_WORDS-1] <= round_w;
                    r_a   <= round_tmp;
                    r_b   <= r_a;
                    r_c   <= rotl(r_b, 30);
                    r_d   <= r_c;
                    r_e   <= r_d;
                    r_rnd <= r_rnd + 1'b1;
                    if (r_rnd == RND_LAST) begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    r_h[0] <= r_h[0] + r_a;
                    r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c;
                    r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                    if (!r_pad) begin
                        r_state <= S_IDLE;
                    end else if (r_spill) begin
                        // length did not fit: a second block, zero but for the length, carries it
                        r_spill <= 1'b0;
                        r_first <= 1'b0;
                        r_widx  <= '0;
                        r_state <= S_PAD;
                    end else begin
                        r_err   <= 1'b0;
                        r_onum  <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_onum <= r_onum + 1'b1;
                        if (r_err || r_onum == WORD_NUM_LAST) begin
                            r_pos   <= '0;
                            r_bc    <= '0;
                            r_ovf   <= 1'b0;
                            r_pad   <= 1'b0;
                            r_state <= S_IDLE;
                            for (int i = 0; i < CHAIN_N; i++) begin
                                r_h[i] <= H_INIT[i];
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_err) begin
                r_odigest <= '0;
                r_onumber <= '0;
                r_ook     <= 1'b0;
                r_olast   <= 1'b1;
            end else begin
                r_odigest <= sel_digest;
                r_onumber <= r_onum;
                r_ook     <= 1'b1;
                r_olast   <= (r_onum == WORD_NUM_LAST);
            end
        end
    end

    assign o_valid       = r_ovalid;
    assign o_digest_word = r_odigest;
    assign o_word_number = r_onumber;
    assign o_ok          = r_ook;
    assign o_last_word   = r_olast;

`ifndef ASSERT_OFF
    a_rnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_rnd <= RND_LAST))
        else $error("round counter past last round");

    a_no_write_in_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND || r_state == S_CREAD) |-> !ram_we)
        else $error("block ram written during compression");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |=> (r_ovalid && $stable(r_odigest) && $stable(r_onumber)))
        else $error("stalled result beat lost or changed");

    a_onum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_onum <= WORD_NUM_LAST))
        else $error("digest word number out of range");

    a_fold_after_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOLD) |-> ($past(r_state) == S_ROUND && $past(r_rnd) == RND_LAST))
        else $error("chain fold without a full round pass");
`endif

endmodule

// ===== verif/tb_sha1_hash_engine_core.sv =====
`timescale 1ns / 100ps
// testbench for the sha1 engine core: queued byte streams in, digest beats checked
module tb_sha1_hash_engine_core;
    import sha1he_pkg::*;

    typedef enum logic {KIND_BYTE = 1'b0, KIND_END = 1'b1} t_beat_kind;
    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill;

    typedef struct packed {
        t_beat_kind  kind;
        logic [7:0]  data;
    } t_msg_beat;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  num;
        logic        ok;
        logic        last;
    } t_digest_beat;

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    localparam int N_PHASES = 4;
    localparam int SEND_IDLE_PCT [N_PHASES] = '{0, 82, 0, 38};
    localparam int RECV_STALL_PCT [N_PHASES] = '{0, 0, 82, 38};
    localparam int BOUNDARY_LENS [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
    localparam int HOLD_CYCLES = 500;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_beat_kind  i_kind = KIND_BYTE;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_number;
    logic        o_ok;
    logic        o_last_word;

    sha1_hash_engine_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_word (o_digest_word),
        .o_word_number (o_word_number),
        .o_ok          (o_ok),
        .o_last_word   (o_last_word)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // predictor state
    logic [31:0]  blk_w [16];
    logic [31:0]  chain_h [CHAIN_N];
    logic [63:0]  msg_bits;
    logic [5:0]   byte_pos;
    logic         len_ovf;
    t_digest_beat digest_q [$];

    t_msg_beat    beat_q [$];
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    logic         pressure_go = 1'b0;
    logic         hold_off = 1'b0;
    int           mismatches = 0;

    function automatic void chain_restart();
        for (int i = 0; i < CHAIN_N; i++) chain_h[i] = H_INIT[i];
        msg_bits = '0;
        byte_pos = '0;
        len_ovf  = 1'b0;
    endfunction

    // big-endian lanes, a lane-0 byte clears the rest of the word
    function automatic void put_byte(input logic [5:0] pos, input logic [7:0] b);
        if (pos[1:0] == 2'd0) begin
            blk_w[pos[5:2]] = {b, 24'h000000};
        end else begin
            blk_w[pos[5:2]][8 * (3 - pos[1:0]) +: 8] = b;
        end
    endfunction

    function automatic void sha1_compress();
        logic [31:0] a, b, c, d, e, w, f, k, t;
        int unsigned s;
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < 80; r++) begin
            s = r % 16;
            // schedule rolls in place over the 16 block words
            if (r >= 16) begin
                w = blk_w[(s + 13) % 16] ^ blk_w[(s + 8) % 16] ^ blk_w[(s + 2) % 16] ^ blk_w[s];
                w = {w[30:0], w[31]};
                blk_w[s] = w;
            end else begin
                w = blk_w[s];
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = K_0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K_1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_2;
            end else begin
                f = b ^ c ^ d;
                k = K_3;
            end
            t = {a[26:0], a[31:27]} + f + e + w + k;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    function automatic void sha1_absorb(input t_msg_beat bt);
        logic [6:0] p;
        if (bt.kind == KIND_BYTE) begin
            // bytes after a length overflow are dropped
            if (!len_ovf) begin
                put_byte(byte_pos, bt.data);
                msg_bits += 64'd8;
                if (msg_bits == '0) len_ovf = 1'b1;
                byte_pos += 6'd1;
                if (byte_pos == '0) sha1_compress();
            end
        end else if (len_ovf) begin
            digest_q.push_back('{word: '0, num: '0, ok: 1'b0, last: 1'b1});
            chain_restart();
        end else begin
            put_byte(byte_pos, PAD_BYTE);
            for (p = {1'b0, byte_pos} + 7'd1; p < 7'd64; p++) put_byte(p[5:0], 8'h00);
            // no room for the length, spill into a second block
            if (byte_pos > 6'd55) begin
                sha1_compress();
                for (p = 7'd0; p < 7'd56; p++) put_byte(p[5:0], 8'h00);
            end
            blk_w[14] = msg_bits[63:32];
            blk_w[15] = msg_bits[31:0];
            sha1_compress();
            for (int i = 0; i < CHAIN_N; i++) begin
                digest_q.push_back('{word: chain_h[i], num: 3'(i), ok: 1'b1,
                                     last: (3'(i) == WORD_NUM_LAST)});
            end
            chain_restart();
        end
    endfunction

    task automatic queue_beat(input t_beat_kind kind, input logic [7:0] data);
        beat_q.push_back('{kind: kind, data: data});
    endtask

    task automatic queue_msg(input int len, input t_fill fill);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                default:   b = 8'($urandom_range(0, 255));
            endcase
            queue_beat(KIND_BYTE, b);
        end
        // data on an end beat must be ignored
        queue_beat(KIND_END, 8'($urandom_range(0, 255)));
    endtask

    function automatic int pick_len();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 12) return $urandom_range(0, 8);
        if (sel < 17) return BOUNDARY_LENS[$urandom_range(0, 7)];
        return $urandom_range(9, 130);
    endfunction

    function automatic t_fill pick_fill();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return FILL_ZERO;
        if (sel == 1) return FILL_ONES;
        return FILL_RANDOM;
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_msg_beat nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) sha1_absorb('{kind: i_kind, data: i_data_byte});
            if (!i_valid || !o_stall) begin
                if (beat_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = beat_q.pop_front();
                    i_valid     <= 1'b1;
                    i_kind      <= nxt.kind;
                    i_data_byte <= nxt.data;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_digest_beat got, want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got = '{word: o_digest_word, num: o_word_number, ok: o_ok, last: o_last_word};
                if (digest_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected digest beat: word %h num %0d ok %b last %b",
                                 got.word, got.num, got.ok, got.last);
                    end
                end else begin
                    want = digest_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("digest beat mismatch: expected word %h num %0d ok %b last %b",
                                     want.word, want.num, want.ok, want.last);
                            $display("                      got      word %h num %0d ok %b last %b",
                                     got.word, got.num, got.ok, got.last);
                        end
                    end
                end
            end
            i_stall <= hold_off || ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // long receiver hold-off so the core backs up into its input
    initial begin
        wait (pressure_go);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        int items;
        int msgs;
        int len;
        for (int i = 0; i < 16; i++) blk_w[i] = '0;
        chain_restart();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty message, then short ones with extreme bytes, then "abc"
        queue_beat(KIND_END, 8'hFF);
        queue_beat(KIND_BYTE, 8'h00);
        queue_beat(KIND_END, 8'h00);
        queue_beat(KIND_BYTE, 8'hFF);
        queue_beat(KIND_END, 8'h5A);
        queue_beat(KIND_BYTE, 8'h61);
        queue_beat(KIND_BYTE, 8'h62);
        queue_beat(KIND_BYTE, 8'h63);
        queue_beat(KIND_END, 8'hA5);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            @(negedge i_clk);
            send_idle_pct  = SEND_IDLE_PCT[ph];
            recv_stall_pct = RECV_STALL_PCT[ph];
            if (ph == 0) pressure_go = 1'b1;
            items = 0;
            msgs  = 0;
            while (items < 25 || msgs < 2) begin
                len = pick_len();
                queue_msg(len, pick_fill());
                items += len + 1;
                msgs++;
            end
            while (beat_q.size() != 0) @(posedge i_clk);
        end

        while (i_valid || digest_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (mismatches == 0 && digest_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
sv/sha1he_pkg.sv
sv/sha1he_ram.sv
sv/sha1_hash_engine_core.sv
verif/tb_sha1_hash_engine_core.sv
